FILE: design/sapt_pkg.sv
// ----------------------------------------------------------------------------
// sapt_pkg: shared types and constants of the segment and page translator
// Word formats of both channels, the decoded command that travels from the
// front end to the back end, and the status groups passed between them.
// ----------------------------------------------------------------------------
package sapt_pkg;

  // Page directory and page table depth, and the index widths they imply.
  localparam int PAGE_ENTRIES = 1024;
  localparam int PAGE_IDX_W   = 10;
  // A selector carries a 13-bit descriptor index in bits 15..3.
  localparam int SEL_IDX_W    = 13;
  // Depth of the command queue between front end and back end.
  localparam int Q_DEPTH      = 2;

  // Operation codes of the input word.
  localparam logic [2:0] OP_WR_GDT = 3'd0;
  localparam logic [2:0] OP_WR_LDT = 3'd1;
  localparam logic [2:0] OP_WR_DIR = 3'd2;
  localparam logic [2:0] OP_WR_PT  = 3'd3;
  localparam logic [2:0] OP_XLATE  = 3'd4;

  // Input word.
  typedef struct packed {
    logic [2:0]  op;
    logic [9:0]  entry_index;
    logic [63:0] entry_data;
    logic [31:0] logical_offset;
    logic [15:0] selector;
  } sapt_in_t;

  // Result word.
  typedef struct packed {
    logic [31:0] physical_address;
    logic        invalid;
  } sapt_out_t;

  // Decoded command kinds; a fault is a translate that fails its selector checks.
  typedef enum logic [2:0] {
    CMD_WR_GDT,
    CMD_WR_LDT,
    CMD_WR_DIR,
    CMD_WR_PT,
    CMD_XLATE,
    CMD_FAULT
  } cmd_kind_t;

  // Queued command.
  typedef struct packed {
    cmd_kind_t             kind;
    logic                  use_ldt;
    logic [SEL_IDX_W-1:0]  desc_idx;
    logic [PAGE_IDX_W-1:0] page_idx;
    logic [63:0]           data;
    logic [31:0]           offset;
  } sapt_cmd_t;

  // Queue status seen by both ends.
  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  // Back end status seen by the front end.
  typedef struct packed {
    logic clearing;
  } bk_stat_t;

  // Back end sequencer states.
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DESC,
    BK_PAGE
  } bk_state_t;

endpackage

FILE: design/sapt_front.sv
// ----------------------------------------------------------------------------
// sapt_front: command acceptance and classification
// Takes input words, drops unused codes and out-of-range descriptor writes,
// screens translate selectors and pushes decoded commands into the queue.
// ----------------------------------------------------------------------------
module sapt_front import sapt_pkg::*; #(
  parameter int DESC_ENTRIES = 256
) (
  input  logic      start,
  input  sapt_in_t  in_word,
  input  q_stat_t   q_stat,
  input  bk_stat_t  bk_stat,
  output logic      busy,
  output logic      push,
  output sapt_cmd_t cmd
);

  localparam int IW = SEL_IDX_W + 1;
  localparam logic [IW-1:0] DESC_LIM = IW'(DESC_ENTRIES);

  logic                 accept;
  logic                 keep;
  logic [SEL_IDX_W-1:0] sel_idx;
  logic [SEL_IDX_W-1:0] wr_idx;
  logic                 sel_in_range;
  logic                 wr_in_range;

  // Hold off new words while the stores are cleared or the queue is full.
  assign busy   = bk_stat.clearing || q_stat.full;
  assign accept = start && !busy;

  // Descriptor indexes from the selector and from the write index.
  assign sel_idx      = in_word.selector[15:3];
  assign wr_idx       = SEL_IDX_W'(in_word.entry_index);
  assign sel_in_range = {1'b0, sel_idx} < DESC_LIM;
  assign wr_in_range  = {1'b0, wr_idx} < DESC_LIM;

  // Classify the word into a queued command.
  always_comb begin
    cmd.kind     = CMD_FAULT;
    cmd.use_ldt  = in_word.selector[2];
    cmd.desc_idx = sel_idx;
    cmd.page_idx = in_word.entry_index;
    cmd.data     = in_word.entry_data;
    cmd.offset   = in_word.logical_offset;
    keep         = 1'b0;
    unique case (in_word.op)
      OP_WR_GDT: begin
        cmd.kind     = CMD_WR_GDT;
        cmd.desc_idx = wr_idx;
        keep         = wr_in_range;
      end
      OP_WR_LDT: begin
        cmd.kind     = CMD_WR_LDT;
        cmd.desc_idx = wr_idx;
        keep         = wr_in_range;
      end
      OP_WR_DIR: begin
        cmd.kind = CMD_WR_DIR;
        keep     = 1'b1;
      end
      OP_WR_PT: begin
        cmd.kind = CMD_WR_PT;
        keep     = 1'b1;
      end
      OP_XLATE: begin
        keep = 1'b1;
        // A null global selector or an index past the table fails at once.
        if ((!in_word.selector[2] && sel_idx == '0) || !sel_in_range) begin
          cmd.kind = CMD_FAULT;
        end else begin
          cmd.kind = CMD_XLATE;
        end
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign push = accept && keep;

endmodule

FILE: design/sapt_queue.sv
// ----------------------------------------------------------------------------
// sapt_queue: command queue between front end and back end
// A small first-in first-out buffer of decoded commands.
// ----------------------------------------------------------------------------
module sapt_queue import sapt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  sapt_cmd_t cmd_in,
  input  logic      pop,
  output sapt_cmd_t head,
  output q_stat_t   q_stat
);

  localparam int QAW = $clog2(Q_DEPTH);
  localparam logic [QAW:0] Q_FULL = (QAW + 1)'(Q_DEPTH);

  sapt_cmd_t        entries_r [Q_DEPTH];
  logic [QAW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]     count_r, count_nxt;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= cmd_in;
    end
  end

  assign head         = entries_r[rd_ptr_r];
  assign q_stat.empty = (count_r == '0);
  assign q_stat.full  = (count_r == Q_FULL);

endmodule

FILE: design/sapt_back.sv
// ----------------------------------------------------------------------------
// sapt_back: table storage and translation sequencer
// Holds the descriptor tables, page directory and page table, clears them
// after reset, performs writes and walks each translate through the
// descriptor read and the directory and page reads.
// ----------------------------------------------------------------------------
module sapt_back import sapt_pkg::*; #(
  parameter int DESC_ENTRIES = 256
) (
  input  logic      clk,
  input  logic      rst_n,
  input  q_stat_t   q_stat,
  input  sapt_cmd_t head,
  output logic      pop,
  output bk_stat_t  bk_stat,
  output logic      out_strobe,
  output sapt_out_t out_word
);

  localparam int DAW       = $clog2(DESC_ENTRIES);
  localparam int CLR_DEPTH = (DESC_ENTRIES > PAGE_ENTRIES) ? DESC_ENTRIES : PAGE_ENTRIES;
  localparam int CW        = $clog2(CLR_DEPTH);
  localparam logic [CW-1:0] CLR_LAST = CW'(CLR_DEPTH - 1);
  localparam logic [CW:0]   DESC_LIM = (CW + 1)'(DESC_ENTRIES);

  // Segment base from a descriptor.
  function automatic logic [31:0] seg_base(input logic [63:0] d);
    seg_base = {d[63:56], d[39:16]};
  endfunction

  // Segment limit from a descriptor, scaled by 4K when granularity is set.
  function automatic logic [31:0] seg_limit(input logic [63:0] d);
    logic [19:0] raw;
    raw = {d[51:48], d[15:0]};
    if (d[55]) begin
      seg_limit = {raw, 12'hFFF};
    end else begin
      seg_limit = {12'h000, raw};
    end
  endfunction

  // Table storage.
  logic [63:0] gdt_mem [DESC_ENTRIES];
  logic [63:0] ldt_mem [DESC_ENTRIES];
  logic [31:0] dir_mem [PAGE_ENTRIES];
  logic [31:0] pt_mem  [PAGE_ENTRIES];
  logic [63:0] gdt_rd_r, ldt_rd_r;
  logic [31:0] dir_rd_r, pt_rd_r;

  logic                  gdt_we, ldt_we, dir_we, pt_we;
  logic [DAW-1:0]        desc_waddr, desc_raddr;
  logic [63:0]           desc_wdata;
  logic [PAGE_IDX_W-1:0] page_waddr, dir_raddr, pt_raddr;
  logic [31:0]           page_wdata;

  logic            clr_active_r, clr_active_nxt;
  logic [CW-1:0]   clr_cnt_r, clr_cnt_nxt;
  logic            clr_desc_ok;
  bk_state_t       state_r, state_nxt;
  logic            cur_ldt_r, cur_ldt_nxt;
  logic [31:0]     cur_off_r, cur_off_nxt;
  logic [31:0]     lin_r, lin_nxt;
  logic            fail_r, fail_nxt;
  logic            out_strobe_r, out_strobe_nxt;
  sapt_out_t       out_word_r, out_word_nxt;

  logic [63:0]     desc_sel;
  logic [31:0]     lin_calc;
  logic            lim_fail;
  logic            page_ok;

  // Descriptor checks and linear address.
  assign desc_sel    = cur_ldt_r ? ldt_rd_r : gdt_rd_r;
  assign lin_calc    = cur_off_r + seg_base(desc_sel);
  assign lim_fail    = cur_off_r > seg_limit(desc_sel);
  assign page_ok     = !fail_r && dir_rd_r[0] && pt_rd_r[0];
  assign clr_desc_ok = {1'b0, clr_cnt_r} < DESC_LIM;

  // Clearing pass, memory control and sequencer.
  always_comb begin
    state_nxt      = state_r;
    clr_active_nxt = clr_active_r;
    clr_cnt_nxt    = clr_cnt_r;
    cur_ldt_nxt    = cur_ldt_r;
    cur_off_nxt    = cur_off_r;
    lin_nxt        = lin_r;
    fail_nxt       = fail_r;
    out_strobe_nxt = 1'b0;
    out_word_nxt   = out_word_r;
    pop            = 1'b0;
    gdt_we         = 1'b0;
    ldt_we         = 1'b0;
    dir_we         = 1'b0;
    pt_we          = 1'b0;
    desc_waddr     = head.desc_idx[DAW-1:0];
    desc_wdata     = head.data;
    page_waddr     = head.page_idx;
    page_wdata     = head.data[31:0];
    desc_raddr     = head.desc_idx[DAW-1:0];
    dir_raddr      = lin_calc[31:22];
    pt_raddr       = lin_calc[21:12];
    if (clr_active_r) begin
      // Zero one entry of each table per cycle; the descriptor tables only while the count is within their depth.
      gdt_we      = clr_desc_ok;
      ldt_we      = clr_desc_ok;
      dir_we      = 1'b1;
      pt_we       = 1'b1;
      desc_waddr  = clr_cnt_r[DAW-1:0];
      desc_wdata  = '0;
      page_waddr  = clr_cnt_r[PAGE_IDX_W-1:0];
      page_wdata  = '0;
      clr_cnt_nxt = clr_cnt_r + 1'b1;
      if (clr_cnt_r == CLR_LAST) begin
        clr_active_nxt = 1'b0;
      end
    end else begin
      unique case (state_r)
        BK_IDLE: begin
          if (!q_stat.empty) begin
            pop = 1'b1;
            unique case (head.kind)
              CMD_WR_GDT: gdt_we = 1'b1;
              CMD_WR_LDT: ldt_we = 1'b1;
              CMD_WR_DIR: dir_we = 1'b1;
              CMD_WR_PT:  pt_we  = 1'b1;
              CMD_XLATE: begin
                // Descriptor read is issued from the queue head.
                cur_ldt_nxt = head.use_ldt;
                cur_off_nxt = head.offset;
                state_nxt   = BK_DESC;
              end
              CMD_FAULT: begin
                out_strobe_nxt                = 1'b1;
                out_word_nxt.physical_address = '0;
                out_word_nxt.invalid          = 1'b1;
              end
              default: begin
                pop = 1'b1;
              end
            endcase
          end
        end
        BK_DESC: begin
          // Directory and page reads are issued at the fresh linear address.
          lin_nxt   = lin_calc;
          fail_nxt  = lim_fail;
          state_nxt = BK_PAGE;
        end
        BK_PAGE: begin
          out_strobe_nxt                = 1'b1;
          out_word_nxt.physical_address = page_ok ? {pt_rd_r[31:12], lin_r[11:0]} : '0;
          out_word_nxt.invalid          = !page_ok;
          state_nxt                     = BK_IDLE;
        end
        default: begin
          state_nxt = BK_IDLE;
        end
      endcase
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_cnt_r    <= '0;
      state_r      <= BK_IDLE;
      out_strobe_r <= 1'b0;
    end else begin
      clr_active_r <= clr_active_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      state_r      <= state_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cur_ldt_r  <= cur_ldt_nxt;
    cur_off_r  <= cur_off_nxt;
    lin_r      <= lin_nxt;
    fail_r     <= fail_nxt;
    out_word_r <= out_word_nxt;
  end

  // Global descriptor table.
  always_ff @(posedge clk) begin
    if (gdt_we) begin
      gdt_mem[desc_waddr] <= desc_wdata;
    end
    gdt_rd_r <= gdt_mem[desc_raddr];
  end

  // Local descriptor table.
  always_ff @(posedge clk) begin
    if (ldt_we) begin
      ldt_mem[desc_waddr] <= desc_wdata;
    end
    ldt_rd_r <= ldt_mem[desc_raddr];
  end

  // Page directory.
  always_ff @(posedge clk) begin
    if (dir_we) begin
      dir_mem[page_waddr] <= page_wdata;
    end
    dir_rd_r <= dir_mem[dir_raddr];
  end

  // Page table.
  always_ff @(posedge clk) begin
    if (pt_we) begin
      pt_mem[page_waddr] <= page_wdata;
    end
    pt_rd_r <= pt_mem[pt_raddr];
  end

  assign bk_stat.clearing = clr_active_r;
  assign out_strobe       = out_strobe_r;
  assign out_word         = out_word_r;

endmodule

FILE: design/segment_and_page_translator_unit.sv
// ----------------------------------------------------------------------------
// segment_and_page_translator_unit: segmented and paged address translator
// Descriptor tables, page directory and page table with a translate command.
// ----------------------------------------------------------------------------
// Usage:
// A word on in_word is taken at a rising edge where start is high and busy
// is low. Op codes 0 to 3 load one entry of the global descriptor table, the
// local descriptor table, the page directory or the page table; they give no
// result. Op 4 translates selector:offset and gives one result word, shown
// on out_word for a single cycle while out_strobe is high. Other codes are
// taken and dropped. Results come in the order of acceptance.
// A write is done as the back end takes it from the queue. A translate steps
// the back end through its idle, descriptor and page states: descriptor read,
// then directory and page reads in parallel, each a synchronous memory read;
// out_strobe is registered after the page state. A selector that fails its
// checks is answered as the back end takes it from the queue. A two-word
// queue lets the front end take words while the back end works; busy is high
// only while that queue is full or the tables are cleared. After reset every
// table is zeroed with busy held high. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module segment_and_page_translator_unit import sapt_pkg::*; #(
  parameter int DESC_ENTRIES = 256
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  sapt_in_t  in_word,
  output logic      out_strobe,
  output sapt_out_t out_word
);

  logic      push;
  logic      pop;
  sapt_cmd_t cmd;
  sapt_cmd_t head;
  q_stat_t   q_stat;
  bk_stat_t  bk_stat;

  // Front end: acceptance and classification.
  sapt_front #(
    .DESC_ENTRIES(DESC_ENTRIES)
  ) u_front (
    .start   (start),
    .in_word (in_word),
    .q_stat  (q_stat),
    .bk_stat (bk_stat),
    .busy    (busy),
    .push    (push),
    .cmd     (cmd)
  );

  // Command queue.
  sapt_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .cmd_in (cmd),
    .pop    (pop),
    .head   (head),
    .q_stat (q_stat)
  );

  // Back end: tables and translation sequencer.
  sapt_back #(
    .DESC_ENTRIES(DESC_ENTRIES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .head       (head),
    .pop        (pop),
    .bk_stat    (bk_stat),
    .out_strobe (out_strobe),
    .out_word   (out_word)
  );

`ifndef SYNTHESIS
  // Reset starts the clearing pass, which keeps the input closed.
  a_reset_busy: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("busy not raised after reset");

  // No result may come out while the tables are being cleared.
  a_no_result_clear: assert property (@(posedge clk) disable iff (!rst_n)
    bk_stat.clearing |-> !out_strobe)
    else $error("result word during clearing pass");

  // A failed translation always reports a zero address.
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_word.invalid) |-> (out_word.physical_address == '0))
    else $error("invalid result with nonzero address");

  // The front end never pushes into a full queue.
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_stat.full)
    else $error("push into full queue");

  // The back end never pops an empty queue.
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("pop from empty queue");
`endif

endmodule
